/* sv/baro_pressure_temp_compensation_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation unit
// Shared implication and next-cycle implication checks, clocked and reset
// gated in one place so each use stays on a single line.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BPTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BPTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bptc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric compensation package
// Field widths, register indexes, reset values and fixed limits shared by
// the stream interfaces and the compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    // Field widths
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int PRES_W     = 18;
    localparam int TEMP_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Pipeline depth in register stages
    localparam int NSTG = 13;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_SENS     = 3'd0,
        CFG_CAL_OFFSET   = 3'd1,
        CFG_CAL_TCS      = 3'd2,
        CFG_CAL_TCO      = 3'd3,
        CFG_CAL_TREF     = 3'd4,
        CFG_CAL_TEMPSENS = 3'd5,
        CFG_P_FLOOR      = 3'd6,
        CFG_P_CEILING    = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [PRES_W-1:0] P_FLOOR_RST   = 18'd1000;
    localparam logic [PRES_W-1:0] P_CEILING_RST = 18'd120000;

    // Temperature thresholds (first-order TEMP) and output limits
    localparam logic signed [19:0]       TEMP_REF  = 20'sd2000;
    localparam logic signed [19:0]       TEMP_VLOW = -20'sd1500;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 15'sd8500;

endpackage

/* sv/bptc_in_if.sv */
// ----------------------------------------------------------------------------
// Raw sample stream interface
// Carries one D1/D2 conversion pair per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bptc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bptc_pkg::RAW_W-1:0] raw_pressure;
    logic [bptc_pkg::RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature,
                    input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature,
                    output ready);
endinterface

/* sv/bptc_out_if.sv */
// ----------------------------------------------------------------------------
// Compensated result stream interface
// Carries one pressure/temperature result per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bptc_out_if;
    logic                               valid;
    logic                               ready;
    logic [bptc_pkg::PRES_W-1:0]        pressure_out;
    logic signed [bptc_pkg::TEMP_W-1:0] temperature_out;

    modport source (output valid, output pressure_out, output temperature_out,
                    input ready);
    modport sink   (input valid, input pressure_out, input temperature_out,
                    output ready);
endinterface

/* sv/baro_pressure_temp_compensation_unit.sv */
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation unit
// Second-order compensation of raw D1/D2 pairs into hundredths of a millibar
// and of a degree, with saturation, as a thirteen-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless the output stalls (o_out.ready low);
// each stage holds one item and its valid bit.
// A stage refills as soon as its item moves on, so bubbles close up under stall.
// Reset (synchronous, active low) clears all valid bits and loads register
// defaults: calibration words 0, pressure floor 1000, pressure ceiling 120000.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_unit_macros.svh"

module baro_pressure_temp_compensation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bptc_in_if.sink                             i_in,
    bptc_out_if.source                          o_out
);

    localparam int NS = bptc_pkg::NSTG;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bptc_pkg::CAL_W-1:0]  r_cal_sens, r_cal_offset, r_cal_tcs, r_cal_tco;
    logic [bptc_pkg::CAL_W-1:0]  r_cal_tref, r_cal_tempsens;
    logic [bptc_pkg::PRES_W-1:0] r_p_floor, r_p_ceiling;

    // Decode writes by register index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_sens     <= '0;
            r_cal_offset   <= '0;
            r_cal_tcs      <= '0;
            r_cal_tco      <= '0;
            r_cal_tref     <= '0;
            r_cal_tempsens <= '0;
            r_p_floor      <= bptc_pkg::P_FLOOR_RST;
            r_p_ceiling    <= bptc_pkg::P_CEILING_RST;
        end else if (i_cfg_we) begin
            unique case (bptc_pkg::t_cfg_idx'(i_cfg_idx))
                bptc_pkg::CFG_CAL_SENS:     r_cal_sens     <= i_cfg_data[15:0];
                bptc_pkg::CFG_CAL_OFFSET:   r_cal_offset   <= i_cfg_data[15:0];
                bptc_pkg::CFG_CAL_TCS:      r_cal_tcs      <= i_cfg_data[15:0];
                bptc_pkg::CFG_CAL_TCO:      r_cal_tco      <= i_cfg_data[15:0];
                bptc_pkg::CFG_CAL_TREF:     r_cal_tref     <= i_cfg_data[15:0];
                bptc_pkg::CFG_CAL_TEMPSENS: r_cal_tempsens <= i_cfg_data[15:0];
                bptc_pkg::CFG_P_FLOOR:      r_p_floor      <= i_cfg_data;
                bptc_pkg::CFG_P_CEILING:    r_p_ceiling    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // A stage loads when it is empty or its item moves on downstream
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_en[0];
    assign o_out.valid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: dT = D2 - TREF * 2^8
    // ------------------------------------------------------------------
    logic signed [24:0] r0_dt;
    logic [23:0]        r0_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_dt <= $signed({1'b0, i_in.raw_temperature}) - $signed({1'b0, r_cal_tref, 8'b0});
            r0_d1 <= i_in.raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: dT products with TEMPSENS, TCO, TCS and itself
    // ------------------------------------------------------------------
    logic signed [41:0] r1_mt, r1_mo, r1_ms;
    logic signed [49:0] r1_dd;
    logic [23:0]        r1_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_mt <= r0_dt * $signed({1'b0, r_cal_tempsens});
            r1_mo <= r0_dt * $signed({1'b0, r_cal_tco});
            r1_ms <= r0_dt * $signed({1'b0, r_cal_tcs});
            r1_dd <= r0_dt * r0_dt;
            r1_d1 <= r0_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-order TEMP, OFF, SENS and T2 (truncate toward zero)
    // ------------------------------------------------------------------
    logic signed [41:0] n2_mt_adj, n2_mo_adj, n2_ms_adj;
    logic signed [19:0] n2_temp1;
    logic signed [41:0] n2_off1, n2_sens1;

    always_comb begin
        n2_mt_adj = r1_mt + (r1_mt[41] ? 42'sd8388607 : 42'sd0);
        n2_mo_adj = r1_mo + (r1_mo[41] ? 42'sd127 : 42'sd0);
        n2_ms_adj = r1_ms + (r1_ms[41] ? 42'sd255 : 42'sd0);
        n2_temp1  = bptc_pkg::TEMP_REF + 20'($signed(n2_mt_adj[41:23]));
        n2_off1   = $signed({10'b0, r_cal_offset, 16'b0}) + 42'($signed(n2_mo_adj[41:7]));
        n2_sens1  = $signed({11'b0, r_cal_sens, 15'b0}) + 42'($signed(n2_ms_adj[41:8]));
    end

    logic signed [19:0] r2_temp1;
    logic signed [41:0] r2_off1, r2_sens1;
    logic [18:0]        r2_t2;
    logic [23:0]        r2_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_temp1 <= n2_temp1;
            r2_off1  <= n2_off1;
            r2_sens1 <= n2_sens1;
            r2_t2    <= r1_dd[49:31];
            r2_d1    <= r1_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: range flags, square operands, final temperature with clamp
    // ------------------------------------------------------------------
    logic               n3_low, n3_vlow;
    logic signed [20:0] n3_temp2;
    logic signed [14:0] n3_temp;

    always_comb begin
        n3_low   = r2_temp1 < bptc_pkg::TEMP_REF;
        n3_vlow  = r2_temp1 < bptc_pkg::TEMP_VLOW;
        n3_temp2 = 21'(r2_temp1) - (n3_low ? $signed({2'b0, r2_t2}) : 21'sd0);
        if (n3_temp2 < 21'(bptc_pkg::TEMP_MIN)) begin
            n3_temp = bptc_pkg::TEMP_MIN;
        end else if (n3_temp2 > 21'(bptc_pkg::TEMP_MAX)) begin
            n3_temp = bptc_pkg::TEMP_MAX;
        end else begin
            n3_temp = n3_temp2[14:0];
        end
    end

    logic signed [19:0] r3_x, r3_y;
    logic               r3_low, r3_vlow;
    logic signed [14:0] r3_temp;
    logic signed [41:0] r3_off1, r3_sens1;
    logic [23:0]        r3_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_x     <= r2_temp1 - bptc_pkg::TEMP_REF;
            r3_y     <= r2_temp1 - bptc_pkg::TEMP_VLOW;
            r3_low   <= n3_low;
            r3_vlow  <= n3_vlow;
            r3_temp  <= n3_temp;
            r3_off1  <= r2_off1;
            r3_sens1 <= r2_sens1;
            r3_d1    <= r2_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of (TEMP - 2000) and (TEMP + 1500)
    // ------------------------------------------------------------------
    logic signed [39:0] n4_a, n4_b;

    assign n4_a = r3_x * r3_x;
    assign n4_b = r3_y * r3_y;

    logic [39:0]        r4_a, r4_b;
    logic               r4_low, r4_vlow;
    logic signed [14:0] r4_temp;
    logic signed [41:0] r4_off1, r4_sens1;
    logic [23:0]        r4_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_a     <= n4_a;
            r4_b     <= n4_b;
            r4_low   <= r3_low;
            r4_vlow  <= r3_vlow;
            r4_temp  <= r3_temp;
            r4_off1  <= r3_off1;
            r4_sens1 <= r3_sens1;
            r4_d1    <= r3_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: OFF2 and SENS2 by shift-and-add constant products
    // ------------------------------------------------------------------
    logic [43:0] n5_a5, n5_b7, n5_b11, n5_off2, n5_sens2;

    always_comb begin
        n5_a5  = {2'b0, r4_a, 2'b0} + {4'b0, r4_a};
        n5_b7  = {1'b0, r4_b, 3'b0} - {4'b0, r4_b};
        n5_b11 = {1'b0, r4_b, 3'b0} + {3'b0, r4_b, 1'b0} + {4'b0, r4_b};
        n5_off2  = '0;
        n5_sens2 = '0;
        if (r4_low) begin
            n5_off2  = (n5_a5 >> 1) + (r4_vlow ? n5_b7 : 44'd0);
            n5_sens2 = (n5_a5 >> 2) + (r4_vlow ? (n5_b11 >> 1) : 44'd0);
        end
    end

    logic [43:0]        r5_off2, r5_sens2;
    logic signed [14:0] r5_temp;
    logic signed [41:0] r5_off1, r5_sens1;
    logic [23:0]        r5_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
            r5_temp  <= r4_temp;
            r5_off1  <= r4_off1;
            r5_sens1 <= r4_sens1;
            r5_d1    <= r4_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: OFF -= OFF2, SENS -= SENS2
    // ------------------------------------------------------------------
    logic signed [45:0] n6_off, n6_sens;

    assign n6_off  = 46'(r5_off1) - $signed({2'b0, r5_off2});
    assign n6_sens = 46'(r5_sens1) - $signed({2'b0, r5_sens2});

    logic signed [41:0] r6_off, r6_sens;
    logic signed [14:0] r6_temp;
    logic [23:0]        r6_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_off  <= n6_off[41:0];
            r6_sens <= n6_sens[41:0];
            r6_temp <= r5_temp;
            r6_d1   <= r5_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS as two partial products on split SENS
    // ------------------------------------------------------------------
    logic [43:0]        r7_pplo;
    logic signed [46:0] r7_pphi;
    logic signed [41:0] r7_off;
    logic signed [14:0] r7_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_pplo <= r6_d1 * r6_sens[19:0];
            r7_pphi <= $signed({1'b0, r6_d1}) * $signed(r6_sens[41:20]);
            r7_off  <= r6_off;
            r7_temp <= r6_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: combine partial products
    // ------------------------------------------------------------------
    logic signed [66:0] r8_prod;
    logic signed [41:0] r8_off;
    logic signed [14:0] r8_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_prod <= $signed({r7_pphi, 20'b0}) + $signed({23'b0, r7_pplo});
            r8_off  <= r7_off;
            r8_temp <= r7_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: D1 * SENS / 2^21, toward zero
    // ------------------------------------------------------------------
    logic signed [66:0] n9_adj;

    assign n9_adj = r8_prod + (r8_prod[66] ? 67'sd2097151 : 67'sd0);

    logic signed [45:0] r9_q;
    logic signed [41:0] r9_off;
    logic signed [14:0] r9_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_q    <= n9_adj[66:21];
            r9_off  <= r8_off;
            r9_temp <= r8_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: subtract OFF
    // ------------------------------------------------------------------
    logic signed [46:0] r10_r;
    logic signed [14:0] r10_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r10_r    <= 47'(r9_q) - 47'(r9_off);
            r10_temp <= r9_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: divide by 2^15, toward zero
    // ------------------------------------------------------------------
    logic signed [46:0] n11_adj;

    assign n11_adj = r10_r + (r10_r[46] ? 47'sd32767 : 47'sd0);

    logic signed [31:0] r11_p;
    logic signed [14:0] r11_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r11_p    <= n11_adj[46:15];
            r11_temp <= r10_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: saturate pressure to floor, then ceiling; output register
    // ------------------------------------------------------------------
    logic [17:0] n12_pres;

    always_comb begin
        if (r11_p < $signed({14'b0, r_p_floor})) begin
            n12_pres = r_p_floor;
        end else if (r11_p > $signed({14'b0, r_p_ceiling})) begin
            n12_pres = r_p_ceiling;
        end else begin
            n12_pres = r11_p[17:0];
        end
    end

    logic [17:0]        r12_pres;
    logic signed [14:0] r12_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r12_pres <= n12_pres;
            r12_temp <= r11_temp;
        end
    end

    assign o_out.pressure_out    = r12_pres;
    assign o_out.temperature_out = r12_temp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BPTC_ASSERT_IMP(a_temp_in_range, i_clk, i_rst_n, o_out.valid, (o_out.temperature_out >= bptc_pkg::TEMP_MIN) && (o_out.temperature_out <= bptc_pkg::TEMP_MAX), "temperature result outside limits")
    `BPTC_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !r_vld[NS-1], i_in.ready, "input stalled with empty output stage")
    `BPTC_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "accepted beat missing from first stage")
    `BPTC_ASSERT_IMP(a_vlow_implies_low, i_clk, i_rst_n, r_vld[4] && r4_vlow, r4_low, "extra correction without second-order correction")

endmodule
